### hw/rtl/swcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcs_pkg
// Shared widths, codes and types of the staleness weighted choice selector.
// ----------------------------------------------------------------------------
package swcs_pkg;

    localparam int MAX_ENTRIES_DEF = 16;

    localparam int CMD_W     = 2;
    localparam int INDEX_W   = 4;
    localparam int SUCC_W    = 17;
    localparam int TIME_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int SCORE_W   = 49;
    localparam int WEIGHT_W  = 18;
    localparam int PROD_W    = TIME_W + WEIGHT_W;
    localparam int FOLD_W    = 20;
    localparam int RECIP_W   = 32;
    localparam int DIVP_W    = FOLD_W + RECIP_W;
    localparam int DIV_SHIFT = 35;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SELECT = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd3;

    localparam logic [SUCC_W-1:0]  ONE_Q16     = 17'h10000;
    localparam logic [RECIP_W-1:0] DIV10_RECIP = 32'hCCCCCCCD;

    typedef struct packed {
        logic [SUCC_W-1:0] succ;
        logic [TIME_W-1:0] last;
    } swcs_entry_t;

    typedef struct packed {
        logic shift;
        logic wr_en;
    } swcs_cell_ctl_t;

endpackage

### hw/rtl/swcs_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcs_req_if
// Command channel: valid/ready handshake with the command payload.
// ----------------------------------------------------------------------------
interface swcs_req_if;
    import swcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [INDEX_W-1:0]  entry_index;
    logic [SUCC_W-1:0]   success_sample;
    logic [TIME_W-1:0]   now_time;

    modport source (output valid, cmd, entry_index, success_sample, now_time,
                    input ready);
    modport sink (input valid, cmd, entry_index, success_sample, now_time,
                  output ready);
endinterface

### hw/rtl/swcs_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcs_rsp_if
// Result channel: valid/ready handshake with the result payload.
// ----------------------------------------------------------------------------
interface swcs_rsp_if;
    import swcs_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  result_index;
    logic [SCORE_W-1:0]  best_score;

    modport source (output valid, status, result_index, best_score,
                    input ready);
    modport sink (input valid, status, result_index, best_score,
                  output ready);
endinterface

### hw/rtl/swcs_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcs_cell
// One table entry: loads from its neighbor while the ring rotates, or takes
// a write addressed to its own position.
// ----------------------------------------------------------------------------
module swcs_cell #(
    parameter int CELL_POS = 0,
    parameter int IDX_W    = 4
) (
    input  logic                   clk,
    input  swcs_pkg::swcs_cell_ctl_t ctl,
    input  logic [IDX_W-1:0]       wr_idx,
    input  swcs_pkg::swcs_entry_t  wr_data,
    input  swcs_pkg::swcs_entry_t  nbr,
    output swcs_pkg::swcs_entry_t  q
);
    import swcs_pkg::*;

    localparam logic [IDX_W-1:0] MY_POS = IDX_W'(CELL_POS);

    swcs_entry_t entry_reg;
    swcs_entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift)
        begin
            entry_next = nbr;
        end
        else if (ctl.wr_en && (wr_idx == MY_POS))
        begin
            entry_next = wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign q = entry_reg;
endmodule

### hw/rtl/swcs_scorer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swcs_scorer
// Scores the entry at the head of the ring and keeps the running best.
// ----------------------------------------------------------------------------
module swcs_scorer #(
    parameter int IDX_W = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  swcs_pkg::swcs_entry_t            head,
    input  logic [swcs_pkg::TIME_W-1:0]      now_time,
    input  logic                             tag_vld,
    input  logic [IDX_W-1:0]                 tag_idx,
    output logic [swcs_pkg::PROD_W-1:0]      best_score,
    output logic [IDX_W-1:0]                 best_idx
);
    import swcs_pkg::*;

    logic [TIME_W-1:0]   age;
    logic [SUCC_W-1:0]   succ_clamped;
    logic [WEIGHT_W-1:0] weight;
    logic [PROD_W-1:0]   p_score_next;

    logic                p_vld_reg;
    logic [PROD_W-1:0]   p_score_reg;
    logic [IDX_W-1:0]    p_idx_reg;
    logic [PROD_W-1:0]   best_score_reg;
    logic [IDX_W-1:0]    best_idx_reg;
    logic                take;

    always_comb
    begin
        age          = now_time - head.last;
        succ_clamped = (head.succ > ONE_Q16) ? ONE_Q16 : head.succ;
        weight       = WEIGHT_W'(ONE_Q16) + WEIGHT_W'(succ_clamped);
        p_score_next = PROD_W'(age) * PROD_W'(weight);
        // The first entry of a scan always seeds the running best.
        take = p_vld_reg && ((p_idx_reg == '0) || (p_score_reg > best_score_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else
        begin
            p_vld_reg <= tag_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        p_score_reg <= p_score_next;
        p_idx_reg   <= tag_idx;
        if (take)
        begin
            best_score_reg <= p_score_reg;
            best_idx_reg   <= p_idx_reg;
        end
    end

    assign best_score = best_score_reg;
    assign best_idx   = best_idx_reg;
endmodule

### hw/rtl/staleness_weighted_choice_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// staleness_weighted_choice_selector_unit
// Table of choices with success estimates and last-used times; inserts,
// updates and selects the stalest weighted choice.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload
//  req      in   cmd, entry_index, success_sample, now_time
//  rsp      out  status, result_index, best_score
//
// Insert and rejected commands go from IDLE to RESP, update through FOLD_A
// and FOLD_B, and select through SCAN and DRAIN, scanning by the ring of cells
// rotating once past the single scorer. One transaction is in flight at a
// time. Reset clears the entry count and the control state; table contents
// are written by insert before they are read. A stalled result holds in the
// output register while the next transaction is accepted.
// ----------------------------------------------------------------------------
module staleness_weighted_choice_selector_unit #(
    parameter int MAX_ENTRIES = swcs_pkg::MAX_ENTRIES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    swcs_req_if.sink   req,
    swcs_rsp_if.source rsp
);
    import swcs_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(MAX_ENTRIES - 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_FOLD_A = 3'd1;
    localparam logic [2:0] ST_FOLD_B = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_RESP   = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic                rsp_valid_reg, rsp_valid_next;

    logic [TIME_W-1:0]   now_reg, now_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [SUCC_W-1:0]   old_reg, old_next;
    logic [SUCC_W-1:0]   smp_reg, smp_next;
    logic [FOLD_W-1:0]   t_reg, t_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [INDEX_W-1:0]  res_idx_reg, res_idx_next;
    logic                res_sel_reg, res_sel_next;
    logic [STATUS_W-1:0] rsp_status_reg;
    logic [INDEX_W-1:0]  rsp_index_reg;
    logic [SCORE_W-1:0]  rsp_score_reg;

    logic                acc;
    logic                load_rsp;
    logic [IDX_W-1:0]    req_idx;
    logic                idx_ok;
    logic [DIVP_W-1:0]   div_prod;
    logic [SUCC_W-1:0]   fold_q;
    logic                scan_vld;

    swcs_cell_ctl_t      cell_ctl;
    logic [IDX_W-1:0]    wr_idx;
    swcs_entry_t         wr_data;
    swcs_entry_t         cell_q [MAX_ENTRIES];

    logic [PROD_W-1:0]   best_score;
    logic [IDX_W-1:0]    best_idx;

    assign req.ready = (state_reg == ST_IDLE);
    assign acc       = req.valid && req.ready;
    assign load_rsp  = (state_reg == ST_RESP) && (!rsp_valid_reg || rsp.ready);
    assign req_idx   = IDX_W'(32'(req.entry_index));
    assign idx_ok    = (32'(req.entry_index) < 32'(count_reg));
    assign div_prod  = DIVP_W'(t_reg) * DIVP_W'(DIV10_RECIP);
    assign fold_q    = div_prod[DIV_SHIFT+SUCC_W-1:DIV_SHIFT];
    assign scan_vld  = (state_reg == ST_SCAN) && (CNT_W'(k_reg) < count_reg);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        k_next          = k_reg;
        rsp_valid_next  = rsp_valid_reg;
        now_next        = now_reg;
        idx_next        = idx_reg;
        old_next        = old_reg;
        smp_next        = smp_reg;
        t_next          = t_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_sel_next    = res_sel_reg;
        cell_ctl.shift  = 1'b0;
        cell_ctl.wr_en  = 1'b0;
        wr_idx          = count_reg[IDX_W-1:0];
        wr_data.succ    = ONE_Q16;
        wr_data.last    = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    now_next        = req.now_time;
                    idx_next        = req_idx;
                    res_status_next = STATUS_OK;
                    res_idx_next    = '0;
                    res_sel_next    = 1'b0;
                    state_next      = ST_RESP;
                    case (req.cmd)
                        CMD_INSERT:
                        begin
                            if (count_reg >= CNT_MAX)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                cell_ctl.wr_en = 1'b1;
                                count_next     = count_reg + 1'b1;
                                res_idx_next   = INDEX_W'(32'(count_reg));
                            end
                        end
                        CMD_UPDATE:
                        begin
                            if (!idx_ok)
                            begin
                                res_status_next = STATUS_NOT_FOUND;
                            end
                            else
                            begin
                                old_next   = cell_q[req_idx].succ;
                                smp_next   = (req.success_sample > ONE_Q16) ?
                                             ONE_Q16 : req.success_sample;
                                state_next = ST_FOLD_A;
                            end
                        end
                        CMD_SELECT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                res_sel_next = 1'b1;
                                k_next       = '0;
                                state_next   = ST_SCAN;
                            end
                        end
                        default:
                        begin
                            res_status_next = STATUS_OK;
                        end
                    endcase
                end
            end
            ST_FOLD_A:
            begin
                if (old_reg > ONE_Q16)
                begin
                    t_next = (FOLD_W'(ONE_Q16) << 3) + FOLD_W'(ONE_Q16) + FOLD_W'(smp_reg);
                end
                else
                begin
                    t_next = (FOLD_W'(old_reg) << 3) + FOLD_W'(old_reg) + FOLD_W'(smp_reg);
                end
                state_next = ST_FOLD_B;
            end
            ST_FOLD_B:
            begin
                cell_ctl.wr_en = 1'b1;
                wr_idx         = idx_reg;
                wr_data.succ   = fold_q;
                wr_data.last   = now_reg;
                res_idx_next   = INDEX_W'(32'(idx_reg));
                state_next     = ST_RESP;
            end
            ST_SCAN:
            begin
                cell_ctl.shift = 1'b1;
                k_next         = k_reg + 1'b1;
                if (k_reg == LAST_POS)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (load_rsp)
                begin
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg        <= now_next;
        idx_reg        <= idx_next;
        old_reg        <= old_next;
        smp_reg        <= smp_next;
        t_reg          <= t_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_sel_reg    <= res_sel_next;
        if (load_rsp)
        begin
            rsp_status_reg <= res_status_reg;
            if (res_sel_reg)
            begin
                rsp_index_reg <= INDEX_W'(32'(best_idx));
                rsp_score_reg <= best_score[SCORE_W-1:0];
            end
            else
            begin
                rsp_index_reg <= res_idx_reg;
                rsp_score_reg <= '0;
            end
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < MAX_ENTRIES; gi++)
        begin : g_cell
            localparam int NXT = (gi + 1) % MAX_ENTRIES;
            swcs_cell #(
                .CELL_POS (gi),
                .IDX_W    (IDX_W)
            ) u_cell (
                .clk     (clk),
                .ctl     (cell_ctl),
                .wr_idx  (wr_idx),
                .wr_data (wr_data),
                .nbr     (cell_q[NXT]),
                .q       (cell_q[gi])
            );
        end
    endgenerate

    swcs_scorer #(
        .IDX_W (IDX_W)
    ) u_scorer (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (cell_q[0]),
        .now_time   (now_reg),
        .tag_vld    (scan_vld),
        .tag_idx    (k_reg),
        .best_score (best_score),
        .best_idx   (best_idx)
    );

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = rsp_status_reg;
    assign rsp.result_index = rsp_index_reg;
    assign rsp.best_score   = rsp_score_reg;
endmodule

### bench/tb_staleness_weighted_choice_selector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_staleness_weighted_choice_selector_unit
// Self-checking bench for the staleness weighted choice selector. A directed
// sequence covers the empty table, unknown indexes, sample clamping, time
// wrap, select ties and the unused command. Random commands then fill the
// table and mix updates and selects under several idling phases and one long
// result stall. Every result is checked against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_staleness_weighted_choice_selector_unit;
    import swcs_pkg::*;

    localparam int MAX_ENTRIES  = MAX_ENTRIES_DEF;
    localparam int RANDOM_ITEMS = 1200;
    localparam int STALL_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = MAX_ENTRIES + 24;
    localparam int LONG_HOLD    = 400;

    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] entry_index;
        logic [SUCC_W-1:0]  success_sample;
        logic [TIME_W-1:0]  now_time;
    } choice_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  result_index;
        logic [SCORE_W-1:0]  best_score;
    } choice_result_t;

    logic clk = 1'b0;
    logic rst_n;

    swcs_req_if req_if ();
    swcs_rsp_if rsp_if ();

    staleness_weighted_choice_selector_unit #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_if),
        .rsp  (rsp_if)
    );

    choice_cmd_t    command_queue[$];
    choice_result_t predicted_results[$];
    choice_cmd_t    offered;
    choice_result_t oldest;

    logic [SUCC_W-1:0] model_success   [MAX_ENTRIES];
    logic [TIME_W-1:0] model_last_used [MAX_ENTRIES];
    int unsigned       model_entries = 0;

    int unsigned cmd_accepted = 0;
    int unsigned results_checked = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_left = 0;
    bit          long_hold_done = 1'b0;
    int unsigned cmd_tally[4] = '{default: 0};
    int unsigned status_tally[4] = '{default: 0};
    logic [1:0]  idle_phase;

    assign idle_phase = 2'((cmd_accepted / 100) % 4);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic choice_result_t predict_choice(choice_cmd_t item);
        choice_result_t res;
        logic [SUCC_W-1:0] sample;
        logic [SUCC_W-1:0] succ;
        logic [TIME_W-1:0] age;
        logic [63:0]       score;
        logic [63:0]       top_score;
        int unsigned       top_index;
        res = '0;
        case (item.cmd)
            CMD_INSERT:
            begin
                if (model_entries >= MAX_ENTRIES) begin
                    res.status = STATUS_FULL;
                end else begin
                    model_success[model_entries]   = ONE_Q16;
                    model_last_used[model_entries] = '0;
                    res.result_index = INDEX_W'(model_entries);
                    model_entries++;
                end
            end
            CMD_UPDATE:
            begin
                if (32'(item.entry_index) >= model_entries) begin
                    res.status = STATUS_NOT_FOUND;
                end else begin
                    sample = (item.success_sample > ONE_Q16) ? ONE_Q16 : item.success_sample;
                    model_success[item.entry_index] = SUCC_W'(
                        (9 * 32'(model_success[item.entry_index]) + 32'(sample)) / 10);
                    model_last_used[item.entry_index] = item.now_time;
                    res.result_index = item.entry_index;
                end
            end
            CMD_SELECT:
            begin
                if (model_entries == 0) begin
                    res.status = STATUS_EMPTY;
                end else begin
                    top_score = '0;
                    top_index = 0;
                    for (int i = 0; i < model_entries; i++) begin
                        age   = item.now_time - model_last_used[i];
                        succ  = (model_success[i] > ONE_Q16) ? ONE_Q16 : model_success[i];
                        score = 64'(age) * (64'(ONE_Q16) + 64'(succ));
                        if (i == 0 || score > top_score) begin
                            top_score = score;
                            top_index = i;
                        end
                    end
                    res.result_index = INDEX_W'(top_index);
                    res.best_score   = SCORE_W'(top_score);
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic bit holds_off(int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    task automatic push_command(input logic [CMD_W-1:0] cmd, input int unsigned index,
                                input int unsigned sample, input logic [TIME_W-1:0] now);
        choice_cmd_t item;
        item.cmd            = cmd;
        item.entry_index    = INDEX_W'(index);
        item.success_sample = SUCC_W'(sample);
        item.now_time       = now;
        command_queue.push_back(item);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_if.valid          <= 1'b0;
            req_if.cmd            <= '0;
            req_if.entry_index    <= '0;
            req_if.success_sample <= '0;
            req_if.now_time       <= '0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                predicted_results.push_back(predict_choice(offered));
                cmd_tally[offered.cmd]++;
                cmd_accepted <= cmd_accepted + 1;
            end
            if (!req_if.valid || req_if.ready) begin
                if (command_queue.size() != 0
                    && !holds_off(idle_phase == 2'd1 ? 79 : idle_phase == 2'd3 ? 9 : 0)) begin
                    offered = command_queue.pop_front();
                    req_if.valid          <= 1'b1;
                    req_if.cmd            <= offered.cmd;
                    req_if.entry_index    <= offered.entry_index;
                    req_if.success_sample <= offered.success_sample;
                    req_if.now_time       <= offered.now_time;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rsp_if.ready <= 1'b0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                results_checked++;
                if (predicted_results.size() == 0) begin
                    $error("Unexpected result: status %0d, result_index %0d, best_score %0d",
                           rsp_if.status, rsp_if.result_index, rsp_if.best_score);
                    mismatches++;
                end else begin
                    oldest = predicted_results.pop_front();
                    status_tally[rsp_if.status]++;
                    if (rsp_if.status !== oldest.status) begin
                        $error("status: expected %0d, actual %0d", oldest.status, rsp_if.status);
                        mismatches++;
                    end
                    if (rsp_if.result_index !== oldest.result_index) begin
                        $error("result_index: expected %0d, actual %0d",
                               oldest.result_index, rsp_if.result_index);
                        mismatches++;
                    end
                    if (rsp_if.best_score !== oldest.best_score) begin
                        $error("best_score: expected %0d, actual %0d",
                               oldest.best_score, rsp_if.best_score);
                        mismatches++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (!long_hold_done && results_checked >= 700) begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= !holds_off(idle_phase == 2'd2 ? 79 : idle_phase == 2'd3 ? 9 : 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        choice_cmd_t item;
        int unsigned useful;
        int unsigned roll;
        int unsigned gen_entries;
        logic [TIME_W-1:0] clock_now;

        rst_n = 1'b0;

        push_command(CMD_SELECT, 0, 0, 32'd0);
        push_command(CMD_UPDATE, 0, 40000, 32'd7);
        push_command(CMD_NOP, 15, 131071, 32'hFFFF_FFFF);
        push_command(CMD_INSERT, 9, 0, 32'd0);
        push_command(CMD_INSERT, 0, 0, 32'd0);
        push_command(CMD_UPDATE, 15, 1, 32'd1);
        push_command(CMD_SELECT, 0, 0, 32'hFFFF_FFFF);
        push_command(CMD_UPDATE, 1, 131071, 32'd100);
        push_command(CMD_UPDATE, 0, 0, 32'hFFFF_FFFF);
        push_command(CMD_SELECT, 0, 0, 32'd5);
        push_command(CMD_UPDATE, 1, 65537, 32'd200);
        push_command(CMD_UPDATE, 1, 65536, 32'd300);
        push_command(CMD_SELECT, 0, 0, 32'd300);

        gen_entries = 2;
        clock_now   = 32'd300;
        useful      = 0;
        while (useful < RANDOM_ITEMS) begin
            roll = $urandom_range(99);
            if (roll < ((gen_entries < MAX_ENTRIES) ? 8 : 3)) begin
                item.cmd = CMD_INSERT;
            end else if (roll < 60) begin
                item.cmd = CMD_UPDATE;
            end else if (roll < 97) begin
                item.cmd = CMD_SELECT;
            end else begin
                item.cmd = CMD_NOP;
            end
            if (gen_entries != 0 && $urandom_range(7) != 0) begin
                item.entry_index = INDEX_W'($urandom_range(gen_entries - 1));
            end else begin
                item.entry_index = INDEX_W'($urandom);
            end
            case ($urandom_range(7))
                0: item.success_sample = '0;
                1: item.success_sample = ONE_Q16;
                2: item.success_sample = SUCC_W'($urandom);
                default: item.success_sample = SUCC_W'($urandom_range(32'(ONE_Q16)));
            endcase
            case ($urandom_range(15))
                0: clock_now = $urandom;
                1: clock_now = clock_now - $urandom_range(1000);
                default: clock_now = clock_now + $urandom_range(20000, 1);
            endcase
            item.now_time = clock_now;
            command_queue.push_back(item);
            if (item.cmd == CMD_INSERT && gen_entries < MAX_ENTRIES) begin
                gen_entries++;
            end
            if (item.cmd != CMD_NOP) begin
                useful++;
            end
        end

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        while (command_queue.size() != 0 || req_if.valid || predicted_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d inserts, %0d updates, %0d selects and %0d unused commands.",
                 cmd_tally[CMD_INSERT], cmd_tally[CMD_UPDATE], cmd_tally[CMD_SELECT],
                 cmd_tally[CMD_NOP]);
        $display("Checked %0d results (ok %0d, full %0d, not present %0d, empty %0d).",
                 results_checked, status_tally[STATUS_OK], status_tally[STATUS_FULL],
                 status_tally[STATUS_NOT_FOUND], status_tally[STATUS_EMPTY]);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
